// ----- rtl/core/dvru_pkg.sv -----
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants for the distance-vector route update block.
// ----------------------------------------------------------------------------
package dvru_pkg;

  localparam int NODES   = 16;
  localparam int IDX_W   = 4;
  localparam int COST_W  = 32;
  localparam int HOP_W   = 5;
  localparam int OP_W    = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADV   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [COST_W-1:0] COST_NONE = 32'hFFFF_FFFF;
  localparam logic [COST_W-1:0] COST_MAX  = 32'h7FFF_FFFF;
  localparam logic [HOP_W-1:0]  HOP_NONE  = 5'h1F;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ADV,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   node;
    logic [IDX_W-1:0]   target;
    logic [COST_W-1:0]  cost;
  } cmd_t;

endpackage

// ----- rtl/core/dvru_front.sv -----
// ----------------------------------------------------------------------------
// dvru_front
// Decodes input beats, drops ones that can never act, normalizes costs.
// ----------------------------------------------------------------------------
module dvru_front (
  input  logic                          in_valid,
  input  logic [dvru_pkg::OP_W-1:0]     in_op,
  input  logic [dvru_pkg::IDX_W-1:0]    in_node,
  input  logic [dvru_pkg::IDX_W-1:0]    in_target,
  input  logic [dvru_pkg::COST_W-1:0]   in_cost,
  input  logic [dvru_pkg::IDX_W-1:0]    own_node,
  input  logic                          q_full,
  output logic                          push,
  output dvru_pkg::cmd_t                push_cmd
);
  import dvru_pkg::*;

  logic keep;

  always_comb begin
    keep              = 1'b0;
    push_cmd.kind     = CMD_QUERY;
    push_cmd.node     = in_node;
    push_cmd.target   = in_target;
    push_cmd.cost     = in_cost;
    unique case (in_op)
      OP_LOAD: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_LOAD;
        if (in_cost[COST_W-1]) begin
          push_cmd.cost = COST_NONE;
        end
      end
      OP_ADV: begin
        // unreachable adverts and our own echoes never change the table
        keep          = !in_cost[COST_W-1] && (in_node != own_node);
        push_cmd.kind = CMD_ADV;
      end
      OP_QUERY: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_QUERY;
      end
      default: keep = 1'b0;
    endcase
    push = in_valid && !q_full && keep;
  end

endmodule

// ----- rtl/core/dvru_queue.sv -----
// ----------------------------------------------------------------------------
// dvru_queue
// Short command queue between the decode front and the table back end.
// ----------------------------------------------------------------------------
module dvru_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dvru_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output dvru_pkg::cmd_t  q_cmd
);
  import dvru_pkg::*;

  cmd_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;
  logic [Q_CNT_W-1:0]  cnt_nxt;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/dvru_back.sv -----
// ----------------------------------------------------------------------------
// dvru_back
// Route tables, relaxation of advertised entries and the result register.
// ----------------------------------------------------------------------------
module dvru_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  dvru_pkg::cmd_t                q_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [dvru_pkg::IDX_W-1:0]    out_dest,
  output logic [dvru_pkg::COST_W-1:0]   out_best_cost,
  output logic [dvru_pkg::HOP_W-1:0]    out_hop
);
  import dvru_pkg::*;

  logic [COST_W-1:0] link_cost_r [NODES];
  logic [COST_W-1:0] best_cost_r [NODES];
  logic [HOP_W-1:0]  next_hop_r  [NODES];

  logic              out_valid_r;
  logic              out_kind_r;
  logic [IDX_W-1:0]  out_dest_r;
  logic [COST_W-1:0] out_cost_r;
  logic [HOP_W-1:0]  out_hop_r;

  logic [COST_W-1:0] lc;
  logic [COST_W-1:0] bc;
  logic [COST_W-1:0] sum;
  logic [COST_W-1:0] sat;
  logic              better;
  logic [HOP_W-1:0]  src_hop;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_dest      = out_dest_r;
  assign out_best_cost = out_cost_r;
  assign out_hop       = out_hop_r;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    lc      = link_cost_r[q_cmd.node];
    bc      = best_cost_r[q_cmd.target];
    // both operands are non-negative, so bit 31 of the sum flags overflow
    sum     = {1'b0, lc[COST_W-2:0]} + {1'b0, q_cmd.cost[COST_W-2:0]};
    sat     = sum[COST_W-1] ? COST_MAX : sum;
    better  = bc[COST_W-1] || (sat < bc);
    src_hop = {1'b0, q_cmd.node};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        link_cost_r[i] <= COST_NONE;
        best_cost_r[i] <= COST_NONE;
        next_hop_r[i]  <= HOP_NONE;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        unique case (q_cmd.kind)
          CMD_LOAD: begin
            link_cost_r[q_cmd.node] <= q_cmd.cost;
            best_cost_r[q_cmd.node] <= q_cmd.cost;
            if (q_cmd.cost[COST_W-1] || (q_cmd.cost == '0)) begin
              next_hop_r[q_cmd.node] <= HOP_NONE;
            end else begin
              next_hop_r[q_cmd.node] <= src_hop;
            end
          end
          CMD_ADV: begin
            if (!lc[COST_W-1] && better) begin
              best_cost_r[q_cmd.target] <= sat;
              next_hop_r[q_cmd.target]  <= src_hop;
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_ENTRY;
              out_dest_r  <= q_cmd.target;
              out_cost_r  <= sat;
              out_hop_r   <= src_hop;
            end
          end
          CMD_QUERY: begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_QUERY;
            out_dest_r  <= q_cmd.target;
            out_cost_r  <= bc;
            out_hop_r   <= next_hop_r[q_cmd.target];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/distance_vector_route_update.sv -----
// ----------------------------------------------------------------------------
// distance_vector_route_update
// Distance-vector routing table: link cost loads, relaxation of advertised
// entries with saturating sums, and next-hop queries.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  op, node, target, cost
//   out_     out  out_valid/out_stall kind, dest, best_cost, hop
//   cfg_     in   cfg_valid/cfg_ready own_node
//
// One beat per cycle sustained while in_stall is low; an accepted beat goes
// into a queue entry, then one table read-add-write; queries and improving
// adverts load the result register. The two-entry queue decouples input
// acceptance from output stalls. Synchronous active-low reset sets all costs
// and hops to none. cfg_ready is always high.
// ----------------------------------------------------------------------------
module distance_vector_route_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dvru_pkg::OP_W-1:0]     in_op,
  input  logic [dvru_pkg::IDX_W-1:0]    in_node,
  input  logic [dvru_pkg::IDX_W-1:0]    in_target,
  input  logic [dvru_pkg::COST_W-1:0]   in_cost,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [dvru_pkg::IDX_W-1:0]    out_dest,
  output logic [dvru_pkg::COST_W-1:0]   out_best_cost,
  output logic [dvru_pkg::HOP_W-1:0]    out_hop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvru_pkg::IDX_W-1:0]    cfg_own_node
);
  import dvru_pkg::*;

  logic [IDX_W-1:0] own_node_r;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_node_r <= cfg_own_node;
    end
  end

  dvru_front u_front (
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_node   (in_node),
    .in_target (in_target),
    .in_cost   (in_cost),
    .own_node  (own_node_r),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dvru_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  dvru_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_dest      (out_dest),
    .out_best_cost (out_best_cost),
    .out_hop       (out_hop)
  );

endmodule

// ----- rtl/core/dvru_checker.sv -----
// ----------------------------------------------------------------------------
// dvru_checker
// Port-level checks on the route update block, bound to the top level.
// ----------------------------------------------------------------------------
module dvru_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_kind,
  input  logic [dvru_pkg::IDX_W-1:0]    out_dest,
  input  logic [dvru_pkg::COST_W-1:0]   out_best_cost,
  input  logic [dvru_pkg::HOP_W-1:0]    out_hop
);
  import dvru_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_dest)
      && $stable(out_best_cost) && $stable(out_hop))
    else $error("result changed while stalled");

  a_entry_routed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ENTRY) |-> !out_best_cost[COST_W-1] && !out_hop[HOP_W-1])
    else $error("improved entry without cost or hop");

  a_unknown_no_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_QUERY) && out_best_cost[COST_W-1] |-> out_hop == HOP_NONE)
    else $error("unknown route reports a next hop");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_dest      (out_dest),
  .out_best_cost (out_best_cost),
  .out_hop       (out_hop)
);
